/* src/mat_pkg.sv */
// ----------------------------------------------------------------------------
// mat_pkg: shared types and constants of the multicast ack tracker
// Sizes, action and status codes, config register indexes, packed row word.
// ----------------------------------------------------------------------------
package mat_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int MAX_PACKETS = 256;

  localparam int WIDX_W  = $clog2(MAX_WORKERS);       // worker index
  localparam int WCNT_W  = $clog2(MAX_WORKERS + 1);   // worker count
  localparam int SLOT_W  = $clog2(MAX_PACKETS);       // packet slot index
  localparam int NSLOT_W = $clog2(MAX_PACKETS + 1);   // packet slot count
  localparam int PEND_W  = $clog2(MAX_PACKETS * MAX_WORKERS + 1);
  localparam int PROD_W  = NSLOT_W + WCNT_W;

  localparam int ACTION_W = 3;
  localparam int ADDR_W   = 32;
  localparam int SEQ_W    = 16;
  localparam int STATUS_W = 3;
  localparam int PIM_W    = 9;
  localparam int TICK_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [PIM_W-1:0]  PIM_RESET     = PIM_W'(1);
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(60 * 1000);

  localparam logic [CFG_IDX_W-1:0] CFG_PACKETS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_START   = 3'd0,
    ACT_ADD     = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_ACK_ALL = 3'd3,
    ACT_QUERY   = 3'd4,
    ACT_TICK    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD_SEQ = 3'd1,
    ST_BAD_SRC = 3'd2,
    ST_FULL    = 3'd3,
    ST_DUP     = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_RD     = 5'b00100,
    S_WR     = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic [MAX_WORKERS-1:0] bits;
    logic [WCNT_W-1:0]      cnt;
  } row_t;

endpackage

/* src/multicast_ack_tracker_core.sv */
// ----------------------------------------------------------------------------
// multicast_ack_tracker_core: per-packet, per-receiver ack bookkeeping
// Registers receivers, marks ack bits, reports pending count and timeout.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | action, node_addr, seq_no
//  out     | out_valid/ out_ready | status, packet_done, pending_acks,
//          |                      | all_done, timed_out
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data (always ready)
//
//  Start, tick, spare actions and a bad seq go from idle straight to the last step;
//  query first reads its row. Add, ack and ack-all walk the receiver table one
//  entry a cycle (W registered) until a match or its end; a single ack then adds
//  a row read-modify-write, a whole-message ack one per packet slot.
//  Reset and start clear the rows at once through per-row valid bits.
//  A held result does not block the next word; a finished word waits in the last step.
// ----------------------------------------------------------------------------
module multicast_ack_tracker_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mat_pkg::ACTION_W-1:0]      action,
  input  logic [mat_pkg::ADDR_W-1:0]        node_addr,
  input  logic [mat_pkg::SEQ_W-1:0]         seq_no,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mat_pkg::STATUS_W-1:0]      status,
  output logic                              packet_done,
  output logic [mat_pkg::PEND_W-1:0]        pending_acks,
  output logic                              all_done,
  output logic                              timed_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mat_pkg::CFG_DATA_W-1:0]    cfg_data
);

  mat_pkg::state_t                   state;
  mat_pkg::action_t                  act;
  logic [mat_pkg::ADDR_W-1:0]        addr;
  logic [mat_pkg::PIM_W-1:0]         pim;
  logic [mat_pkg::TICK_W-1:0]        tmo;
  logic [mat_pkg::TICK_W-1:0]        ticks;
  logic [mat_pkg::WCNT_W-1:0]        wcnt;
  logic [mat_pkg::PEND_W-1:0]        total;
  logic [mat_pkg::WCNT_W-1:0]        idx;
  logic [mat_pkg::WIDX_W-1:0]        widx;
  logic [mat_pkg::SLOT_W-1:0]        slot;
  logic [mat_pkg::MAX_PACKETS-1:0]   row_valid;
  logic                              rd_valid;
  mat_pkg::status_t                  res_status;
  logic                              res_pdone;

  logic [mat_pkg::ADDR_W-1:0]        worker_address [mat_pkg::MAX_WORKERS];
  mat_pkg::row_t                     row_mem [mat_pkg::MAX_PACKETS];
  mat_pkg::row_t                     row_rdata;

  logic [mat_pkg::NSLOT_W-1:0]       slot_n;
  logic                              seq_bad;
  logic                              hit;
  mat_pkg::row_t                     row_cur;
  mat_pkg::row_t                     row_new;
  logic                              bit_set;
  logic                              is_ack;
  logic                              row_we;
  logic [mat_pkg::PROD_W-1:0]        expected;
  logic [mat_pkg::PROD_W-1:0]        pending_full;
  logic                              add_we;

  assign in_ready  = (state == mat_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // clamp the slot count into 1..MAX_PACKETS
  always_comb begin
    if (pim == '0) begin
      slot_n = mat_pkg::NSLOT_W'(1);
    end else if (int'(pim) > mat_pkg::MAX_PACKETS) begin
      slot_n = mat_pkg::NSLOT_W'(mat_pkg::MAX_PACKETS);
    end else begin
      slot_n = mat_pkg::NSLOT_W'(pim);
    end
  end

  assign seq_bad = (seq_no >= mat_pkg::SEQ_W'(slot_n));
  assign hit     = (worker_address[idx[mat_pkg::WIDX_W-1:0]] == addr);
  assign is_ack  = (act == mat_pkg::ACT_ACK) || (act == mat_pkg::ACT_ACK_ALL);

  always_comb begin
    row_cur = rd_valid ? row_rdata : '0;
    bit_set = row_cur.bits[widx];
    row_new = row_cur;
    if (is_ack && !bit_set) begin
      row_new.bits = row_cur.bits | (mat_pkg::MAX_WORKERS'(1) << widx);
      row_new.cnt  = row_cur.cnt + mat_pkg::WCNT_W'(1);
    end
  end

  assign row_we = (state == mat_pkg::S_WR) && is_ack && !bit_set;
  assign add_we = (state == mat_pkg::S_SEARCH) && (idx == wcnt) &&
                  (act == mat_pkg::ACT_ADD) &&
                  (wcnt != mat_pkg::WCNT_W'(mat_pkg::MAX_WORKERS));

  assign expected     = mat_pkg::PROD_W'(slot_n) * mat_pkg::PROD_W'(wcnt);
  assign pending_full = (expected > mat_pkg::PROD_W'(total)) ?
                        expected - mat_pkg::PROD_W'(total) : '0;

  // receiver table
  always_ff @(posedge clk) begin
    if (add_we) begin
      worker_address[wcnt[mat_pkg::WIDX_W-1:0]] <= addr;
    end
  end

  // row memory: one port, registered read
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[slot] <= row_new;
    end
    row_rdata <= row_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mat_pkg::S_IDLE;
      pim       <= mat_pkg::PIM_RESET;
      tmo       <= mat_pkg::TIMEOUT_RESET;
      ticks     <= '0;
      wcnt      <= '0;
      total     <= '0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mat_pkg::CFG_PACKETS: pim <= cfg_data[mat_pkg::PIM_W-1:0];
          mat_pkg::CFG_TIMEOUT: tmo <= cfg_data[mat_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      // drop a taken word unless the last step reloads it
      if (out_valid && out_ready && (state != mat_pkg::S_FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        mat_pkg::S_IDLE: begin
          if (in_valid) begin
            act        <= mat_pkg::action_t'(action);
            addr       <= node_addr;
            idx        <= '0;
            res_status <= mat_pkg::ST_OK;
            res_pdone  <= 1'b0;
            slot       <= seq_no[mat_pkg::SLOT_W-1:0];
            state      <= mat_pkg::S_FINISH;
            case (mat_pkg::action_t'(action))
              mat_pkg::ACT_START: begin
                wcnt      <= '0;
                total     <= '0;
                ticks     <= '0;
                row_valid <= '0;
              end
              mat_pkg::ACT_TICK: begin
                if (ticks != '1) begin
                  ticks <= ticks + mat_pkg::TICK_W'(1);
                end
              end
              mat_pkg::ACT_ADD, mat_pkg::ACT_ACK_ALL: begin
                state <= mat_pkg::S_SEARCH;
              end
              mat_pkg::ACT_ACK: begin
                if (seq_bad) begin
                  res_status <= mat_pkg::ST_BAD_SEQ;
                end else begin
                  state <= mat_pkg::S_SEARCH;
                end
              end
              mat_pkg::ACT_QUERY: begin
                if (seq_bad) begin
                  res_status <= mat_pkg::ST_BAD_SEQ;
                end else begin
                  state <= mat_pkg::S_RD;
                end
              end
              default: ;
            endcase
          end
        end

        mat_pkg::S_SEARCH: begin
          if (idx == wcnt) begin
            // end of table without a match
            state <= mat_pkg::S_FINISH;
            if (act == mat_pkg::ACT_ADD) begin
              if (add_we) begin
                wcnt <= wcnt + mat_pkg::WCNT_W'(1);
              end else begin
                res_status <= mat_pkg::ST_FULL;
              end
            end else begin
              res_status <= mat_pkg::ST_BAD_SRC;
            end
          end else if (hit) begin
            widx <= idx[mat_pkg::WIDX_W-1:0];
            if (act == mat_pkg::ACT_ADD) begin
              res_status <= mat_pkg::ST_DUP;
              state      <= mat_pkg::S_FINISH;
            end else begin
              if (act == mat_pkg::ACT_ACK_ALL) begin
                slot <= '0;
              end
              state <= mat_pkg::S_RD;
            end
          end else begin
            idx <= idx + mat_pkg::WCNT_W'(1);
          end
        end

        mat_pkg::S_RD: begin
          rd_valid <= row_valid[slot];
          state    <= mat_pkg::S_WR;
        end

        mat_pkg::S_WR: begin
          if (row_we) begin
            row_valid[slot] <= 1'b1;
            total           <= total + mat_pkg::PEND_W'(1);
          end
          res_pdone <= (act != mat_pkg::ACT_ACK_ALL) && (row_new.cnt == wcnt);
          if ((act == mat_pkg::ACT_ACK_ALL) &&
              (slot != mat_pkg::SLOT_W'(slot_n - mat_pkg::NSLOT_W'(1)))) begin
            slot  <= slot + mat_pkg::SLOT_W'(1);
            state <= mat_pkg::S_RD;
          end else begin
            state <= mat_pkg::S_FINISH;
          end
        end

        mat_pkg::S_FINISH: begin
          // hold until the result register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            packet_done  <= res_pdone;
            pending_acks <= pending_full[mat_pkg::PEND_W-1:0];
            all_done     <= (pending_full == '0);
            timed_out    <= (ticks > tmo);
            state        <= mat_pkg::S_IDLE;
          end
        end

        default: state <= mat_pkg::S_IDLE;
      endcase
    end
  end

endmodule

/* src/mat_check.sv */
// ----------------------------------------------------------------------------
// mat_check: port-level checks of the multicast ack tracker
// Watches the handshakes and the consistency of each result word.
// ----------------------------------------------------------------------------
module mat_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mat_pkg::STATUS_W-1:0]      status,
  input logic                              packet_done,
  input logic [mat_pkg::PEND_W-1:0]        pending_acks,
  input logic                              all_done
);

  // a result word stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pending_acks))
    else $error("result word dropped or changed while stalled");

  // all_done tracks a zero pending count
  a_all_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (all_done == (pending_acks == '0)))
    else $error("all_done disagrees with pending_acks");

  // an error never reports a finished packet
  a_err_pdone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != mat_pkg::ST_OK) |-> !packet_done)
    else $error("packet_done set on an error status");

  // busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in progress");

endmodule

bind multicast_ack_tracker_core mat_check u_mat_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .packet_done  (packet_done),
  .pending_acks (pending_acks),
  .all_done     (all_done)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for multicast_ack_tracker_core
// Feeds start/add/ack/ack-all/query/tick words through a valid/ready driver,
// tracks receivers and ack bits in a local tracker model, and checks every
// result word field by field. Config phases sweep slot count and timeout.
// ----------------------------------------------------------------------------
module tb;

  localparam int POOL_SIZE   = 20;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = mat_pkg::MAX_WORKERS + 2 + 2 * mat_pkg::MAX_PACKETS + 8;

  localparam logic [mat_pkg::ACTION_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [mat_pkg::ACTION_W-1:0] ACT_SPARE7 = 3'd7;

  typedef struct packed {
    logic [mat_pkg::ACTION_W-1:0] act;
    logic [mat_pkg::ADDR_W-1:0]   addr;
    logic [mat_pkg::SEQ_W-1:0]    seq;
  } word_t;

  typedef struct packed {
    mat_pkg::status_t           status;
    logic                       packet_done;
    logic [mat_pkg::PEND_W-1:0] pending;
    logic                       all_done;
    logic                       timed_out;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           in_valid    = 1'b0;
  logic                           in_ready;
  logic [mat_pkg::ACTION_W-1:0]   action      = '0;
  logic [mat_pkg::ADDR_W-1:0]     node_addr   = '0;
  logic [mat_pkg::SEQ_W-1:0]      seq_no      = '0;
  logic                           out_valid;
  logic                           out_ready   = 1'b0;
  logic [mat_pkg::STATUS_W-1:0]   status;
  logic                           packet_done;
  logic [mat_pkg::PEND_W-1:0]     pending_acks;
  logic                           all_done;
  logic                           timed_out;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready;
  logic [mat_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [mat_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

  multicast_ack_tracker_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .node_addr    (node_addr),
    .seq_no       (seq_no),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .packet_done  (packet_done),
    .pending_acks (pending_acks),
    .all_done     (all_done),
    .timed_out    (timed_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // tracker model state
  logic [mat_pkg::PIM_W-1:0]       m_pim = mat_pkg::PIM_RESET;
  logic [mat_pkg::TICK_W-1:0]      m_timeout = mat_pkg::TIMEOUT_RESET;
  logic [mat_pkg::ADDR_W-1:0]      m_recv_addr [mat_pkg::MAX_WORKERS];
  int                              m_recv_count = 0;
  logic [mat_pkg::MAX_WORKERS-1:0] m_ack_bits [mat_pkg::MAX_PACKETS];
  int                              m_ack_count [mat_pkg::MAX_PACKETS];
  int                              m_total = 0;
  logic [mat_pkg::TICK_W-1:0]      m_ticks = '0;

  word_t   pending_words [$];
  report_t want_reports [$];
  word_t   drv_word;
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      quiet_cycles = 0;

  // stimulus generator view of the current message
  logic [mat_pkg::ADDR_W-1:0] g_pool [POOL_SIZE];
  int                         g_slots = 1;

  function automatic int slot_span(logic [mat_pkg::PIM_W-1:0] pim);
    if (pim == 0) return 1;
    if (pim > mat_pkg::MAX_PACKETS) return mat_pkg::MAX_PACKETS;
    return int'(pim);
  endfunction

  function automatic int find_receiver(logic [mat_pkg::ADDR_W-1:0] addr);
    for (int i = 0; i < m_recv_count; i++)
      if (m_recv_addr[i] == addr) return i;
    return -1;
  endfunction

  function automatic void mark_ack(int slot, int idx);
    if (!m_ack_bits[slot][idx]) begin
      m_ack_bits[slot][idx] = 1'b1;
      m_ack_count[slot]++;
      m_total++;
    end
  endfunction

  function automatic report_t tracker_update(word_t w);
    report_t r;
    int      n;
    int      idx;
    int      need;
    int      pend;
    n = slot_span(m_pim);
    r.status = mat_pkg::ST_OK;
    r.packet_done = 1'b0;
    case (w.act)
      mat_pkg::ACT_START: begin
        for (int s = 0; s < mat_pkg::MAX_PACKETS; s++) begin
          m_ack_bits[s] = '0;
          m_ack_count[s] = 0;
        end
        m_recv_count = 0;
        m_total = 0;
        m_ticks = '0;
      end
      mat_pkg::ACT_ADD: begin
        if (find_receiver(w.addr) >= 0) r.status = mat_pkg::ST_DUP;
        else if (m_recv_count >= mat_pkg::MAX_WORKERS) r.status = mat_pkg::ST_FULL;
        else begin
          m_recv_addr[m_recv_count] = w.addr;
          m_recv_count++;
        end
      end
      mat_pkg::ACT_ACK: begin
        idx = find_receiver(w.addr);
        if (int'(w.seq) >= n) r.status = mat_pkg::ST_BAD_SEQ;
        else if (idx < 0) r.status = mat_pkg::ST_BAD_SRC;
        else begin
          mark_ack(int'(w.seq), idx);
          r.packet_done = (m_ack_count[w.seq] == m_recv_count);
        end
      end
      mat_pkg::ACT_ACK_ALL: begin
        idx = find_receiver(w.addr);
        if (idx < 0) r.status = mat_pkg::ST_BAD_SRC;
        else for (int s = 0; s < n; s++) mark_ack(s, idx);
      end
      mat_pkg::ACT_QUERY: begin
        if (int'(w.seq) >= n) r.status = mat_pkg::ST_BAD_SEQ;
        else r.packet_done = (m_ack_count[w.seq] == m_recv_count);
      end
      mat_pkg::ACT_TICK: begin
        if (m_ticks != '1) m_ticks++;
      end
      default: ;
    endcase
    need = n * m_recv_count;
    pend = (need > m_total) ? need - m_total : 0;
    r.pending = pend[mat_pkg::PEND_W-1:0];
    r.all_done = (pend == 0);
    r.timed_out = (m_ticks > m_timeout);
    return r;
  endfunction

  // driver: hold each word until accepted, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) want_reports.push_back(tracker_update(drv_word));
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_word = pending_words.pop_front();
          in_valid <= 1'b1;
          action <= drv_word.act;
          node_addr <= drv_word.addr;
          seq_no <= drv_word.seq;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_report();
    report_t exp;
    if (want_reports.size() == 0) begin
      mismatches++;
      $display("%0t: result word with nothing expected, status %0d", $time, status);
    end else begin
      exp = want_reports.pop_front();
      if (status !== exp.status) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
      end
      if (packet_done !== exp.packet_done) begin
        mismatches++;
        $display("%0t: packet_done expected %0b actual %0b", $time, exp.packet_done,
                 packet_done);
      end
      if (pending_acks !== exp.pending) begin
        mismatches++;
        $display("%0t: pending_acks expected %0d actual %0d", $time, exp.pending,
                 pending_acks);
      end
      if (all_done !== exp.all_done) begin
        mismatches++;
        $display("%0t: all_done expected %0b actual %0b", $time, exp.all_done, all_done);
      end
      if (timed_out !== exp.timed_out) begin
        mismatches++;
        $display("%0t: timed_out expected %0b actual %0b", $time, exp.timed_out, timed_out);
      end
    end
  endtask

  // monitor: check accepted results, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_report();
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("** multicast_ack_tracker_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(logic [mat_pkg::ACTION_W-1:0] act,
                           logic [mat_pkg::ADDR_W-1:0] addr,
                           logic [mat_pkg::SEQ_W-1:0] seq);
    word_t w;
    w.act = act;
    w.addr = addr;
    w.seq = seq;
    pending_words.push_back(w);
  endtask

  task automatic cfg_write(logic [mat_pkg::CFG_IDX_W-1:0] idx,
                           logic [mat_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mat_pkg::CFG_PACKETS) m_pim = data[mat_pkg::PIM_W-1:0];
    else if (idx == mat_pkg::CFG_TIMEOUT) m_timeout = data;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || want_reports.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [mat_pkg::SEQ_W-1:0] pick_seq();
    if ($urandom_range(9) != 0) return mat_pkg::SEQ_W'($urandom_range(g_slots - 1));
    return mat_pkg::SEQ_W'($urandom_range(65535));
  endfunction

  // one message: start and receiver registration, then mostly acks
  task automatic gen_message(int len, bit fresh);
    int nadd;
    int r;
    if (fresh) begin
      for (int k = 0; k < POOL_SIZE; k++) g_pool[k] = $urandom;
      push_word(mat_pkg::ACT_START, $urandom, mat_pkg::SEQ_W'($urandom_range(65535)));
      nadd = $urandom_range(1, 18);
      for (int k = 0; k < nadd; k++) push_word(mat_pkg::ACT_ADD, g_pool[k], pick_seq());
      if ($urandom_range(3) == 0)
        push_word(mat_pkg::ACT_ADD, g_pool[$urandom_range(nadd - 1)], pick_seq());
      len -= nadd + 1;
    end
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 45)
        push_word(mat_pkg::ACT_ACK, g_pool[$urandom_range(POOL_SIZE - 1)], pick_seq());
      else if (r < 55) push_word(mat_pkg::ACT_QUERY, $urandom, pick_seq());
      else if (r < 65) push_word(mat_pkg::ACT_TICK, $urandom, pick_seq());
      else if (r < 69)
        push_word(mat_pkg::ACT_ACK_ALL, g_pool[$urandom_range(POOL_SIZE - 1)], pick_seq());
      else if (r < 79)
        push_word(mat_pkg::ACT_ADD, g_pool[$urandom_range(POOL_SIZE - 1)], pick_seq());
      else begin
        // noise: any action, random fields; keep mid-message restarts rare
        r = $urandom_range(7);
        if (r == mat_pkg::ACT_START && $urandom_range(3) != 0) r = mat_pkg::ACT_TICK;
        push_word(mat_pkg::ACTION_W'(r), $urandom, mat_pkg::SEQ_W'($urandom_range(65535)));
      end
    end
  endtask

  task automatic fill_words(int count, bit fresh);
    int len;
    while (count > 0) begin
      len = $urandom_range(20, 80);
      if (len > count) len = count;
      gen_message(len, fresh);
      count -= len;
      fresh = 1'b1;
    end
  endtask

  task automatic run_phase(logic [mat_pkg::CFG_DATA_W-1:0] pim,
                           logic [mat_pkg::CFG_DATA_W-1:0] tmo,
                           int send_pct, int recv_pct, int count, bit fresh, bit hold);
    cfg_write(mat_pkg::CFG_PACKETS, pim);
    cfg_write(mat_pkg::CFG_TIMEOUT, tmo);
    g_slots = slot_span(pim[mat_pkg::PIM_W-1:0]);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) begin
      fill_words(count / 2, fresh);
      drain();
      fill_words(count - count / 2, 1'b0);
    end else begin
      fill_words(count, fresh);
    end
    drain();
  endtask

  initial begin
    for (int s = 0; s < mat_pkg::MAX_PACKETS; s++) begin
      m_ack_bits[s] = '0;
      m_ack_count[s] = 0;
    end
    for (int k = 0; k < POOL_SIZE; k++) g_pool[k] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: no receivers, bad seq before bad source, duplicates,
    // repeated ack, ack-all, timeout, spare actions, restart
    cfg_write(mat_pkg::CFG_PACKETS, 32'd4);
    cfg_write(mat_pkg::CFG_TIMEOUT, 32'd2);
    push_word(mat_pkg::ACT_QUERY, 32'h0000_0000, 16'd0);
    push_word(mat_pkg::ACT_ACK, 32'h5A5A_A5A5, 16'd0);
    push_word(mat_pkg::ACT_ACK, 32'h5A5A_A5A5, 16'd4);
    push_word(mat_pkg::ACT_ADD, 32'h0000_0000, 16'd0);
    push_word(mat_pkg::ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(mat_pkg::ACT_ADD, 32'hFFFF_FFFF, 16'd0);
    push_word(mat_pkg::ACT_ACK, 32'hFFFF_FFFF, 16'd3);
    push_word(mat_pkg::ACT_ACK, 32'hFFFF_FFFF, 16'd3);
    push_word(mat_pkg::ACT_ACK, 32'h0000_0000, 16'd3);
    push_word(mat_pkg::ACT_QUERY, 32'h0000_0000, 16'd3);
    push_word(mat_pkg::ACT_QUERY, 32'h0000_0000, 16'hFFFF);
    push_word(mat_pkg::ACT_ACK_ALL, 32'h0000_0000, 16'd0);
    push_word(mat_pkg::ACT_ACK_ALL, 32'h5A5A_A5A5, 16'd0);
    push_word(mat_pkg::ACT_ACK_ALL, 32'hFFFF_FFFF, 16'd0);
    push_word(mat_pkg::ACT_TICK, 32'h0000_0000, 16'd0);
    push_word(mat_pkg::ACT_TICK, 32'h0000_0000, 16'd0);
    push_word(mat_pkg::ACT_TICK, 32'h0000_0000, 16'd0);
    push_word(ACT_SPARE6, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(ACT_SPARE7, 32'h0000_0000, 16'd0);
    push_word(mat_pkg::ACT_START, 32'h0000_0000, 16'd0);
    push_word(mat_pkg::ACT_QUERY, 32'h0000_0000, 16'd0);
    drain();

    // random phases; some continue the open message across a slot-count change
    run_phase(32'd8,         32'd10,                 0,  0,  250, 1'b1, 1'b0);
    run_phase(32'hABCD_E003, 32'hFFFF_FFFF,          79, 0,  200, 1'b0, 1'b0);
    run_phase(32'd0,         32'd0,                  0,  79, 150, 1'b1, 1'b0);
    run_phase(32'd256,       32'd30,                 21, 21, 150, 1'b1, 1'b0);
    run_phase(32'd511,       32'd1,                  0,  0,  100, 1'b0, 1'b0);
    run_phase(32'd17,        mat_pkg::TIMEOUT_RESET, 79, 0,  200, 1'b1, 1'b1);
    run_phase(32'd1,         32'd5,                  0,  79, 150, 1'b1, 1'b0);
    run_phase(32'd300,       32'd100,                21, 21, 100, 1'b0, 1'b0);
    run_phase(32'd64,        32'd2,                  0,  0,  250, 1'b1, 1'b0);

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) $display("** multicast_ack_tracker_core: PASSED **");
    else $display("** multicast_ack_tracker_core: FAILED **");
    $finish;
  end

endmodule
